>>> design/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared widths, operation and status codes, and the per-cell command bundle
// for the indexed list with insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

    // Field widths fixed by the interface
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // Default number of cells
    localparam int DEF_CAPACITY = 64;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Value returned on empty or error
    localparam logic [DATA_W-1:0] NEG_ONE = '1;

    // Broadcast to every cell; a flag is set only for an operation that succeeds
    typedef struct packed {
        logic do_append;
        logic do_insert;
        logic do_remove;
    } cell_cmd_t;

endpackage : ilir_pkg

`default_nettype wire

>>> design/indexed_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top
// Ordered list of signed 32-bit entries held in a row of shifting cells.
//
// Usage:
//   Command channel: present kind, position and value with start high; the
//   command transfers at a rising edge where start is high and busy is low.
//   busy stays low, so a new command may transfer at every edge.
//   Result channel: read_data, status and length are shown for exactly one
//   cycle with done high, the cycle after the command transfer.
//   Throughput is one command per cycle: insert and remove shift the cells
//   from the position onward toward their neighbors in parallel in that
//   same edge, and a read picks one cell through a masked OR across the row.
//   The receiver cannot stall; each result must be taken when done is high.
//   Reset (rst_n low, asynchronous) empties the list and clears done; cell
//   contents are not cleared and are never read before they are written.
//   Out-of-range positions, empty pop/peek and writes into a full list give
//   read_data of -1 with the matching status and leave the list unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove_top
    import ilir_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic        [KIND_W-1:0]   kind,
    input  wire logic        [POS_W-1:0]    position,
    input  wire logic signed [DATA_W-1:0]   value,
    output logic                            done,
    output logic signed      [DATA_W-1:0]   read_data,
    output logic             [STATUS_W-1:0] status,
    output logic             [LEN_W-1:0]    length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    logic [DATA_W-1:0]   read_data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [LEN_W-1:0]    length_reg;

    logic                accept;
    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    sel;
    logic                is_full;
    logic                is_empty;
    logic [DATA_W-1:0]   rd_word;
    logic [DATA_W-1:0]   res_data;
    logic [STATUS_W-1:0] res_status;
    cell_cmd_t           cmd;

    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [DATA_W-1:0]   cell_rd   [CAPACITY];

    // Every cycle can take a command
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign count_ext = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(position);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    // Read selects by position, pop and peek select the last entry
    assign sel       = (kind == KIND_READ) ? pos_ext : (count_ext - CMP_W'(1));

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = value;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        ilir_cell #(
            .CMP_W (CMP_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos_ext),
            .count      (count_ext),
            .sel        (sel),
            .value      (value),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // OR of the masked cell outputs; at most one cell is selected
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    // Operation decode, status and new count
    always_comb
    begin
        cmd        = '0;
        res_data   = '0;
        res_status = ST_OK;
        count_next = count_reg;
        unique case (kind)
            KIND_APPEND:
            begin
                if (is_full)
                begin
                    res_data   = NEG_ONE;
                    res_status = ST_FULL;
                end
                else
                begin
                    cmd.do_append = accept;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            KIND_INSERT:
            begin
                if (pos_ext > count_ext)
                begin
                    res_data   = NEG_ONE;
                    res_status = ST_RANGE;
                end
                else if (is_full)
                begin
                    res_data   = NEG_ONE;
                    res_status = ST_FULL;
                end
                else
                begin
                    cmd.do_insert = accept;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE:
            begin
                if (pos_ext >= count_ext)
                begin
                    res_data   = NEG_ONE;
                    res_status = ST_RANGE;
                end
                else
                begin
                    cmd.do_remove = accept;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            KIND_READ:
            begin
                if (pos_ext >= count_ext)
                begin
                    res_data   = NEG_ONE;
                    res_status = ST_RANGE;
                end
                else
                begin
                    res_data = rd_word;
                end
            end
            KIND_POP:
            begin
                if (is_empty)
                begin
                    res_data   = NEG_ONE;
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_data   = rd_word;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_PEEK:
            begin
                if (is_empty)
                begin
                    res_data   = NEG_ONE;
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_data = rd_word;
                end
            end
            default:
            begin
                res_data   = '0;
                res_status = ST_OK;
            end
        endcase
    end

    // Count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= res_data;
            status_reg    <= res_status;
            length_reg    <= LEN_W'(count_next);
        end
    end

    assign done      = done_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;
    assign length    = length_reg;

endmodule : indexed_list_insert_remove_top

`default_nettype wire

>>> design/ilir_cell.sv
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot. Loads the new entry, takes its left neighbor on insert or
// its right neighbor on remove, and drives its entry when selected for read.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_cell
    import ilir_pkg::*;
#(
    parameter int CMP_W = 7,
    parameter int INDEX = 0
)
(
    input  wire logic              clk,
    input  wire cell_cmd_t         cmd,
    input  wire logic [CMP_W-1:0]  pos,
    input  wire logic [CMP_W-1:0]  count,
    input  wire logic [CMP_W-1:0]  sel,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic      [DATA_W-1:0] data,
    output logic      [DATA_W-1:0] rd_data
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              load_val;
    logic              take_left;
    logic              take_right;

    // Slot action from this cell's place relative to position and count
    assign load_val   = (cmd.do_append && (IDX == count)) ||
                        (cmd.do_insert && (IDX == pos));
    assign take_left  = cmd.do_insert && (IDX > pos) && (IDX <= count);
    assign take_right = cmd.do_remove && (IDX >= pos) &&
                        ((IDX + CMP_W'(1)) < count);

    always_comb
    begin
        data_next = data_reg;
        if (load_val)
        begin
            data_next = value;
        end
        else if (take_left)
        begin
            data_next = left_data;
        end
        else if (take_right)
        begin
            data_next = right_data;
        end
    end

    // Entry storage; no reset, read only after written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // Masked read, OR-combined across the row
    assign rd_data = (IDX == sel) ? data_reg : '0;

endmodule : ilir_cell

`default_nettype wire

>>> design/ilir_checker.sv
// ----------------------------------------------------------------------------
// ilir_checker
// Port-level checks for the indexed list: result timing and error results.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_checker
    import ilir_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic [KIND_W-1:0]   kind,
    input wire logic                done,
    input wire logic [DATA_W-1:0]   read_data,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [LEN_W-1:0]    length
);

    // Every command transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result after command transfer");

    // No result without a command transfer in the previous cycle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without command");

    // Empty status only on an empty list, with -1
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> ((length == '0) && (read_data == NEG_ONE)))
        else $error("bad empty result");

    // Empty status only for pop or peek
    a_empty_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |->
        ($past(kind) == KIND_POP || $past(kind) == KIND_PEEK))
        else $error("empty status on wrong operation");

    // Errors right after another result leave the length as it was and return -1
    a_error_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && (status == ST_RANGE || status == ST_FULL)) |->
        ((length == $past(length)) && (read_data == NEG_ONE)))
        else $error("error result changed length or data");

endmodule : ilir_checker

bind indexed_list_insert_remove_top ilir_checker u_ilir_checker (.*);

`default_nettype wire
